// ===== sv/bpa_pkg.sv =====
`default_nettype none

package bpa_pkg;

  // default table geometry
  localparam int unsigned NUM_BLOCKS_DEF = 8;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_BLOCKS = 2'd1;

  // reset value of the blocks in use register
  localparam logic [3:0] BLOCKS_RESET = 4'd8;

  // request kinds
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LOAD    = 2'd2
  } kind_e;

  // placement policies
  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_e;

  // input request payload
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] request_size;
    logic [2:0]  block_index;
    logic [15:0] block_size;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic        granted;
    logic [2:0]  granted_index;
    logic [15:0] granted_size;
  } out_item_t;

  // search token state handed from cell to cell
  typedef struct packed {
    logic tok;
    logic found;
    logic hi;
  } scan_flags_t;

  // per-cell update commands
  typedef struct packed {
    logic clear;
    logic load;
    logic mark;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/block_placement_allocator_core.sv =====
`default_nettype none

// Block placement allocator. Keeps NUM_BLOCKS entries, each a size and an
// allocated flag, and serves one request at a time. An allocate request sends
// a search token down a row of cells, one cell per clock, each cell holding
// one entry and comparing it against the best candidate so far under the
// policy in force (first, best, worst or next fit; ties go to the lowest
// index). An allocate request passes its search token through the go register,
// the flag register of each cell and the search result register before its
// result is committed to the output register; a release-all or load request
// goes from acceptance straight to the result state. The next request is
// taken once a result has been committed, and a stalled output holds a
// finished result in the result state until the output register frees up.
// Every request gives exactly one result. The output register lets a finished
// result wait while the next request is accepted. Configuration writes are
// always taken and must only be issued while the block is idle.

module block_placement_allocator_core
  import bpa_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire in_item_t   in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output out_item_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [3:0] cfg_data_i
);

  localparam int unsigned IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RESULT = 3'b100
  } state_e;

  state_e               state_q;
  policy_e              policy_q;
  logic [3:0]           blocks_q;
  logic [IW-1:0]        nfs_q;
  logic [SIZE_BITS-1:0] req_q;
  logic [CW-1:0]        scan_n_q;
  logic [IW-1:0]        scan_start_q;
  logic                 go_q;
  logic                 res_found_q;
  logic [IW-1:0]        res_idx_q;
  logic [SIZE_BITS-1:0] res_size_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 commit;
  logic                 is_alloc;
  logic [CW-1:0]        n_eff;
  logic [IW-1:0]        start_eff;

  scan_flags_t          flags_c [NUM_BLOCKS+1];
  logic [IW-1:0]        idx_c   [NUM_BLOCKS+1];
  logic [SIZE_BITS-1:0] size_c  [NUM_BLOCKS+1];
  cell_cmd_t            cmd     [NUM_BLOCKS];

  // handshake
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign commit      = (state_q == ST_RESULT) && out_free;
  assign is_alloc    = (kind_e'(in_data_i.kind) == KIND_ALLOC);
  assign cfg_ready_o = 1'b1;

  // entries in use, saturated, and the next fit starting point
  assign n_eff = (int'(blocks_q) > NUM_BLOCKS) ? CW'(NUM_BLOCKS) : CW'(blocks_q);
  assign start_eff = (int'(nfs_q) < int'(n_eff)) ? nfs_q : '0;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      blocks_q <= BLOCKS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_POLICY: policy_q <= policy_e'(cfg_data_i[1:0]);
        CFG_BLOCKS: blocks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      nfs_q   <= '0;
    end else begin
      go_q <= in_acc && is_alloc;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= is_alloc ? ST_SCAN : ST_RESULT;
          end
        end
        ST_SCAN: begin
          if (flags_c[NUM_BLOCKS].tok) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
            if (res_found_q && (policy_q == POL_NEXT)) begin
              nfs_q <= res_idx_q;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // search operands and search result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q        <= SIZE_BITS'(in_data_i.request_size);
      scan_n_q     <= n_eff;
      scan_start_q <= start_eff;
      res_found_q  <= 1'b0;
      res_idx_q    <= '0;
      res_size_q   <= '0;
    end else if ((state_q == ST_SCAN) && flags_c[NUM_BLOCKS].tok) begin
      res_found_q <= flags_c[NUM_BLOCKS].found;
      res_idx_q   <= flags_c[NUM_BLOCKS].found ? idx_c[NUM_BLOCKS] : '0;
      res_size_q  <= flags_c[NUM_BLOCKS].found ? size_c[NUM_BLOCKS] : '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_q.granted       <= res_found_q;
      out_q.granted_index <= 3'(res_idx_q);
      out_q.granted_size  <= 16'(res_size_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // head of the cell row
  assign flags_c[0] = '{tok: go_q, found: 1'b0, hi: 1'b0};
  assign idx_c[0]   = '0;
  assign size_c[0]  = '0;

  // row of entry cells
  for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
    always_comb begin
      cmd[i].clear = in_acc && (kind_e'(in_data_i.kind) == KIND_RELEASE);
      cmd[i].load  = in_acc && (kind_e'(in_data_i.kind) == KIND_LOAD) &&
                     (int'(in_data_i.block_index) == i);
      cmd[i].mark  = commit && res_found_q && (int'(res_idx_q) == i);
    end

    bpa_cell #(
      .IDX       (i),
      .IW        (IW),
      .CW        (CW),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd[i]),
      .wr_size_i (SIZE_BITS'(in_data_i.block_size)),
      .policy_i  (policy_q),
      .count_i   (scan_n_q),
      .start_i   (scan_start_q),
      .req_i     (req_q),
      .flags_i   (flags_c[i]),
      .idx_i     (idx_c[i]),
      .size_i    (size_c[i]),
      .flags_o   (flags_c[i+1]),
      .idx_o     (idx_c[i+1]),
      .size_o    (size_c[i+1])
    );
  end

`ifndef ASSERT_OFF
  // a refused result carries zero index and size
  a_no_grant_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.granted |->
      (out_data_o.granted_index == 3'd0) && (out_data_o.granted_size == 16'd0))
    else $error("refused result with nonzero fields");

  // requests other than allocate skip the search
  a_nonalloc_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !is_alloc |=> (state_q == ST_RESULT) && !go_q)
    else $error("non-allocate request entered the search");

  // the token only leaves the row during a search
  a_token_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_c[NUM_BLOCKS].tok |-> (state_q == ST_SCAN))
    else $error("search token outside a search");

  // an allocate launches exactly one token
  a_go_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |-> (state_q == ST_SCAN) && !$past(go_q))
    else $error("search launched outside a search");
`endif

endmodule

`default_nettype wire

// ===== sv/bpa_cell.sv =====
`default_nettype none

module bpa_cell
  import bpa_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned IW        = 3,
  parameter int unsigned CW        = 4,
  parameter int unsigned SIZE_BITS = SIZE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_cmd_t            cmd_i,
  input  wire logic [SIZE_BITS-1:0] wr_size_i,
  input  wire policy_e              policy_i,
  input  wire logic [CW-1:0]        count_i,
  input  wire logic [IW-1:0]        start_i,
  input  wire logic [SIZE_BITS-1:0] req_i,
  input  wire scan_flags_t          flags_i,
  input  wire logic [IW-1:0]        idx_i,
  input  wire logic [SIZE_BITS-1:0] size_i,
  output scan_flags_t               flags_o,
  output logic [IW-1:0]             idx_o,
  output logic [SIZE_BITS-1:0]      size_o
);

  logic [SIZE_BITS-1:0] size_q;
  logic                 alloc_q;
  logic                 fit;
  logic                 hi;
  logic                 better;
  logic                 take;
  scan_flags_t          flags_q;
  logic [IW-1:0]        idx_q;
  logic [SIZE_BITS-1:0] cand_size_q;

  // entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= '0;
      alloc_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        size_q <= wr_size_i;
      end
      if (cmd_i.clear) begin
        alloc_q <= 1'b0;
      end else if (cmd_i.mark) begin
        alloc_q <= 1'b1;
      end
    end
  end

  // does this entry take part and fit the request
  assign fit = (IDX < int'(count_i)) && !alloc_q && (size_q >= req_i);
  assign hi  = (IDX >= int'(start_i));

  // compare against the candidate handed in by the previous cell
  always_comb begin
    case (policy_i)
      POL_FIRST: better = !flags_i.found;
      POL_BEST:  better = !flags_i.found || (size_q < size_i);
      POL_WORST: better = !flags_i.found || (size_q > size_i);
      POL_NEXT:  better = !flags_i.found || (hi && !flags_i.hi);
      default:   better = 1'b0;
    endcase
  end

  assign take = flags_i.tok && fit && better;

  // token flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q.tok <= flags_i.tok;
      if (take) begin
        flags_q.found <= 1'b1;
        flags_q.hi    <= hi;
      end else begin
        flags_q.found <= flags_i.found;
        flags_q.hi    <= flags_i.hi;
      end
    end
  end

  // candidate payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      idx_q       <= IW'(IDX);
      cand_size_q <= size_q;
    end else begin
      idx_q       <= idx_i;
      cand_size_q <= size_i;
    end
  end

  assign flags_o = flags_q;
  assign idx_o   = idx_q;
  assign size_o  = cand_size_q;

endmodule

`default_nettype wire
